### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the semaphore table.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`endif
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### hdl/cst_pkg.sv
// ---------------------------------------------------------------------------
// Semaphore table package
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package cst_pkg;
    localparam int SEMAPHORES   = 16;
    localparam int WAITERS      = 8;
    localparam int COUNT_BITS   = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int SEM_BITS     = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
    localparam int WPOS_BITS    = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int WLEN_BITS    = $clog2(WAITERS + 1);
    localparam int STORE_DEPTH  = SEMAPHORES * WAITERS;
    localparam int STORE_BITS   = $clog2(STORE_DEPTH) > 0 ? $clog2(STORE_DEPTH) : 1;
    localparam int IN_BITS      = 40;
    localparam int OUT_BITS     = 24;

    localparam logic [1:0] FUNC_OPEN   = 2'd0;
    localparam logic [1:0] FUNC_WAIT   = 2'd1;
    localparam logic [1:0] FUNC_SIGNAL = 2'd2;
    localparam logic [1:0] FUNC_CLOSE  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       close_step;
        logic       emit;
    } cst_cmd_t;

    typedef struct packed {
        logic       is_close;
        logic       close_more;
    } cst_stat_t;
endpackage

### hdl/cst_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/cst_datapath.sv
// ---------------------------------------------------------------------------
// Semaphore table datapath
// Per-handle state, waiter store and result register.
// ---------------------------------------------------------------------------
module cst_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [cst_pkg::IN_BITS-1:0]  in_data,
    input  cst_pkg::cst_cmd_t            cmd,
    output cst_pkg::cst_stat_t           stat,
    output logic [cst_pkg::OUT_BITS-1:0] out_data,
    output logic                         out_last
);
    import cst_pkg::*;

    logic [SEMAPHORES-1:0]   open_reg;
    logic [COUNT_BITS-1:0]   count_reg [SEMAPHORES];
    logic [WPOS_BITS-1:0]    head_reg  [SEMAPHORES];
    logic [WLEN_BITS-1:0]    len_reg   [SEMAPHORES];

    logic [1:0]              func_reg;
    logic [7:0]              hnd_reg;
    logic [15:0]             init_reg;
    logic [TASK_ID_BITS-1:0] task_reg;
    logic [SEM_BITS-1:0]     sem_reg;
    logic                    hvalid_reg;
    logic [WLEN_BITS-1:0]    ci_reg;
    logic [WLEN_BITS-1:0]    cn_reg;
    logic [WPOS_BITS-1:0]    ch_reg;

    logic [1:0]              st_reg;
    logic [7:0]              ho_reg;
    logic                    blk_reg;
    logic                    wv_reg;
    logic                    wt_src_reg;
    logic [TASK_ID_BITS-1:0] wt_reg;
    logic                    last_reg;

    logic                    free_found;
    logic [SEM_BITS-1:0]     free_idx;
    logic                    we;
    logic [STORE_BITS-1:0]   waddr;
    logic [STORE_BITS-1:0]   raddr;
    logic [TASK_ID_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0]   cnt;
    logic [WPOS_BITS-1:0]    hd;
    logic [WLEN_BITS-1:0]    ln;
    logic [WPOS_BITS-1:0]    tail;
    logic [COUNT_BITS-1:0]   init_sat;
    logic                    is_open;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SEMAPHORES - 1; i >= 0; i--) begin
            if (!open_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SEM_BITS'(i);
            end
        end
    end

    assign cnt  = count_reg[sem_reg];
    assign hd   = head_reg[sem_reg];
    assign ln   = len_reg[sem_reg];
    assign tail = WPOS_BITS'((32'(hd) + 32'(ln)) % WAITERS);
    assign is_open = hvalid_reg && open_reg[sem_reg];
    assign init_sat = (32'(init_reg) > ((1 << COUNT_BITS) - 1)) ? '1 : COUNT_BITS'(init_reg);

    assign we    = cmd.exec && func_reg == FUNC_WAIT && is_open && cnt == '0
                   && 32'(ln) < WAITERS;
    assign waddr = STORE_BITS'(32'(sem_reg) * WAITERS + 32'(tail));
    assign raddr = STORE_BITS'(32'(sem_reg) * WAITERS
                   + ((32'(ch_reg) + 32'(ci_reg)) % WAITERS));

    cst_ram #(.WIDTH(TASK_ID_BITS), .DEPTH(STORE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (task_reg),
        .raddr (cmd.exec ? STORE_BITS'(32'(sem_reg) * WAITERS + 32'(hd)) : raddr),
        .rdata (rdata)
    );

    assign stat.is_close   = func_reg == FUNC_CLOSE && is_open && ln != '0;
    assign stat.close_more = ci_reg < cn_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= in_data[1:0];
            hnd_reg    <= in_data[9:2];
            init_reg   <= in_data[25:10];
            task_reg   <= in_data[26 +: TASK_ID_BITS];
            sem_reg    <= SEM_BITS'(in_data[9:2] - 8'd1);
            hvalid_reg <= in_data[9:2] != 8'd0 && 32'(in_data[9:2]) <= SEMAPHORES;
        end
        if (cmd.exec) begin
            ci_reg <= '0;
            cn_reg <= ln;
            ch_reg <= hd;
        end
        if (cmd.close_step) begin
            ci_reg <= ci_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
            for (int i = 0; i < SEMAPHORES; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                len_reg[i]   <= '0;
            end
        end else if (cmd.exec) begin
            unique case (func_reg)
                FUNC_OPEN: begin
                    if (free_found) begin
                        open_reg[free_idx]  <= 1'b1;
                        count_reg[free_idx] <= init_sat;
                        head_reg[free_idx]  <= '0;
                        len_reg[free_idx]   <= '0;
                    end
                end
                FUNC_WAIT: begin
                    if (is_open && cnt != '0) begin
                        count_reg[sem_reg] <= cnt - 1'b1;
                    end else if (we) begin
                        len_reg[sem_reg] <= ln + 1'b1;
                    end
                end
                FUNC_SIGNAL: begin
                    if (is_open) begin
                        if (cnt == '0 && ln != '0) begin
                            head_reg[sem_reg] <= WPOS_BITS'((32'(hd) + 1) % WAITERS);
                            len_reg[sem_reg]  <= ln - 1'b1;
                        end else if (cnt != '1) begin
                            count_reg[sem_reg] <= cnt + 1'b1;
                        end
                    end
                end
                FUNC_CLOSE: begin
                    if (is_open) begin
                        open_reg[sem_reg]  <= 1'b0;
                        count_reg[sem_reg] <= '0;
                        head_reg[sem_reg]  <= '0;
                        len_reg[sem_reg]   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            blk_reg    <= 1'b0;
            wv_reg     <= 1'b0;
            wt_src_reg <= 1'b0;
            last_reg   <= 1'b1;
            st_reg     <= ST_OK;
            ho_reg     <= '0;
            unique case (func_reg)
                FUNC_OPEN: begin
                    st_reg <= free_found ? ST_OK : ST_FAIL;
                    ho_reg <= free_found ? 8'(32'(free_idx) + 1) : 8'd0;
                end
                FUNC_WAIT: begin
                    if (!is_open) begin
                        st_reg <= ST_FAIL;
                    end else if (cnt != '0) begin
                        ho_reg <= hnd_reg;
                    end else if (!we) begin
                        st_reg <= ST_FULL;
                    end else begin
                        ho_reg  <= hnd_reg;
                        blk_reg <= 1'b1;
                    end
                end
                FUNC_SIGNAL: begin
                    if (!is_open) begin
                        st_reg <= ST_FAIL;
                    end else if (cnt == '0 && ln != '0) begin
                        wv_reg     <= 1'b1;
                        wt_src_reg <= 1'b1;
                    end
                end
                FUNC_CLOSE: begin
                    st_reg <= is_open ? ST_OK : ST_FAIL;
                    ho_reg <= is_open ? hnd_reg : 8'd0;
                end
                default: ;
            endcase
        end
        if (cmd.close_step) begin
            wv_reg     <= 1'b1;
            wt_src_reg <= 1'b1;
            last_reg   <= 32'(ci_reg) + 1 == 32'(cn_reg);
        end
        if (cmd.emit) begin
            wt_reg <= wt_src_reg ? rdata : '0;
        end
    end

    assign out_data = {4'd0, wv_reg ? wt_reg : 8'd0, wv_reg, blk_reg, ho_reg, st_reg};
    assign out_last = last_reg;
endmodule

### hdl/cst_ctrl.sv
// ---------------------------------------------------------------------------
// Semaphore table controller
// Sequences load, execute, waiter sweep and result hand-off.
// ---------------------------------------------------------------------------
module cst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output cst_pkg::cst_cmd_t  cmd,
    input  cst_pkg::cst_stat_t stat
);
    import cst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CAP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       close_reg, close_next;

    always_comb begin
        state_next = state_reg;
        close_next = close_reg;
        cmd        = '0;
        s_axis_tready = state_reg == S_IDLE;
        m_axis_tvalid = state_reg == S_OUT;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                close_next = stat.is_close;
                state_next = stat.is_close ? S_RD : S_CAP;
            end
            S_RD: begin
                cmd.close_step = 1'b1;
                state_next     = S_CAP;
            end
            S_CAP: begin
                cmd.emit   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    if (close_reg && stat.close_more) begin
                        state_next = S_RD;
                    end else begin
                        close_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            close_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

`include "assert_macros.svh"
    `ASSERT_CLK(a_one_side, aclk, aresetn, !(s_axis_tready && m_axis_tvalid))
    `ASSERT_CLK(a_load_exec, aclk, aresetn, cmd.load |=> state_reg == S_EXEC)
    `ASSERT_CLK(a_emit_out, aclk, aresetn, cmd.emit |=> m_axis_tvalid)
endmodule

### hdl/counting_semaphore_table.sv
// ---------------------------------------------------------------------------
// Counting semaphore table
// Open, wait, signal and close on a table of counting semaphores with FIFOs.
// ---------------------------------------------------------------------------
// Sequence: an accepted item passes through the execute and capture states and is
// then offered on the output; a new item is accepted only once all results of the
// previous one have been taken. Close emits one result per waiter, each passing
// through a read state and the capture state, set by the registered read of the
// waiter RAM.
// Reset: synchronous; all handles closed, counts and queues cleared.
module counting_semaphore_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // func, handle, initial_count, task_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // status, handle_out, blocked, woken_valid, woken_task
    output logic        m_axis_tlast
);
    import cst_pkg::*;

    cst_cmd_t  cmd;
    cst_stat_t stat;

    cst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    cst_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_data(s_axis_tdata),
        .cmd(cmd), .stat(stat), .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule
